// ===== rtl/stereo_rms_level_meter_defines.svh =====
// Assertion macros for the RTL of the level meter.
// Each one samples on clk and is switched off while arst_n is low.
`ifndef STEREO_RMS_LEVEL_METER_DEFINES_SVH
`define STEREO_RMS_LEVEL_METER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRLM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/srlm_pkg.sv =====
`default_nettype none

package srlm_pkg;

	// Frames per block. Must be a power of two from 1 to 16.
	localparam int FRAMES_PER_BLOCK = 16;
	localparam int BLOCK_LOG2 = $clog2(FRAMES_PER_BLOCK);

	localparam int SAMPLE_W = 16;
	localparam int MAG_W = SAMPLE_W - 1;
	localparam int DIGIT_W = 4;
	localparam int MAG_DIGITS = (MAG_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(MAG_DIGITS);

	localparam int SUM_W = 34;
	localparam int COUNT_W = $clog2(FRAMES_PER_BLOCK + 1);
	localparam int MEAN_W = SUM_W + 1 - BLOCK_LOG2;
	localparam int ROOT_W = MEAN_W + 1;
	localparam int ROOT_STEPS = (MEAN_W + 1) / 2;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

	localparam int LEVEL_W = 16;
	localparam int ACC_W = 24;
	localparam int LVL_SHIFT = ACC_W - LEVEL_W;
	localparam int WEIGHT_W = 16;
	localparam int W_DIGITS = WEIGHT_W / DIGIT_W;
	localparam int WDIG_CNT_W = $clog2(W_DIGITS);
	localparam int PROD_W = ACC_W + WEIGHT_W;

	localparam int PCT_W = 7;
	localparam int PCT_STEPS = PCT_W;
	localparam int PCT_CNT_W = $clog2(PCT_STEPS);
	localparam int DIVD_W = LEVEL_W + PCT_W;

	localparam logic [LEVEL_W-1:0] RMS_MAX = 16'd32768;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4588;
	localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 16'd11141;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} frame_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] block_rms;
		logic [LEVEL_W-1:0] smoothed_level;
		logic [PCT_W-1:0] loudness_percent;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [WEIGHT_W-1:0] value;
	} cfg_write_t;

	typedef struct packed {
		logic valid;
		logic [MEAN_W-1:0] mean;
	} mean_beat_t;

	typedef struct packed {
		logic valid;
		logic [LEVEL_W-1:0] rms;
	} rms_beat_t;

endpackage

`default_nettype wire

// ===== rtl/srlm_channels.sv =====
`default_nettype none

interface srlm_in_if;
	import srlm_pkg::*;
	logic valid;
	logic ready;
	frame_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srlm_out_if;
	import srlm_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srlm_cfg_if;
	import srlm_pkg::*;
	logic valid;
	logic ready;
	cfg_write_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/stereo_rms_level_meter.sv =====
// Stereo block-RMS level meter with a smoothed level and a loudness percent.
// in_ch carries one stereo frame per beat (two signed Q1.15 samples); a beat
// moves when valid and ready are both high at a rising edge of clk.
// out_ch carries one result beat per block of FRAMES_PER_BLOCK frames: the
// block RMS, the smoothed level (both unsigned Q1.15) and the percent of full scale.
// cfg_ch writes register 0 (smoothing weight) or 1 (full-scale level); it is
// always ready, and other indexes are dropped. Write it only while idle.
// A 4-bit digit-serial squarer handles both channels of a frame at once, one
// multiplier digit a cycle; in_ch.ready is high only while it is idle, so no
// new frame is taken until the last one has been squared and summed.
// The result of a block comes from a one-bit-a-cycle square root, a
// digit-serial smoothing multiply and a restoring divide for the percent;
// the divide is skipped when the level is at or above full scale. This back
// end runs while the next block accumulates.
// If out_ch stalls, the result waits in the output register, the back end
// fills up behind it and in_ch.ready drops until the result moves.
// Reset (arst_n low) clears the sum, the frame count, the smoothed level and
// all valid flags, and loads the register defaults.
`default_nettype none
`include "stereo_rms_level_meter_defines.svh"

module stereo_rms_level_meter (
	input  logic        clk,
	input  logic        arst_n,
	srlm_in_if.sink     in_ch,
	srlm_out_if.source  out_ch,
	srlm_cfg_if.sink    cfg_ch
);
	import srlm_pkg::*;

	logic [WEIGHT_W-1:0] weight_q;
	logic [LEVEL_W-1:0] full_scale_q;

	logic frame_ready;
	mean_beat_t mean_beat;
	logic mean_ready;
	rms_beat_t rms_beat;
	logic rms_ready;
	logic result_valid;
	result_t result;

	// Configuration registers. The back end reads them live, which is safe only
	// if the user changes them while no block is in flight; the block does not enforce it.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
			full_scale_q <= FULL_SCALE_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				CFG_WEIGHT: begin
					weight_q <= cfg_ch.data.value;
				end
				CFG_FULL_SCALE: begin
					full_scale_q <= cfg_ch.data.value;
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: halve, square and sum the samples; hands over the mean of
	// the block once FRAMES_PER_BLOCK frames are in.
	srlm_square_acc u_square_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (in_ch.valid),
		.frame       (in_ch.data),
		.frame_ready (frame_ready),
		.mean_beat   (mean_beat),
		.mean_ready  (mean_ready)
	);

	assign in_ch.ready = frame_ready;

	// Square root of the block mean, one root bit per cycle.
	srlm_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.mean_beat  (mean_beat),
		.mean_ready (mean_ready),
		.rms_beat   (rms_beat),
		.rms_ready  (rms_ready)
	);

	// Smoothing, percent and the output register.
	srlm_smoother u_smoother (
		.clk          (clk),
		.arst_n       (arst_n),
		.rms_beat     (rms_beat),
		.rms_ready    (rms_ready),
		.weight       (weight_q),
		.full_scale   (full_scale_q),
		.result_valid (result_valid),
		.result       (result),
		.result_ready (out_ch.ready)
	);

	assign out_ch.valid = result_valid;
	assign out_ch.data = result;

	// The root of a block mean never exceeds RMS_MAX, the full scale of a sample.
	`SRLM_ASSERT_IMP(a_rms_range, rms_beat.valid, rms_beat.rms <= RMS_MAX, "block RMS out of range")
	// The smoothed level stays between zero and the largest block RMS.
	`SRLM_ASSERT_IMP(a_level_range, out_ch.valid, out_ch.data.smoothed_level <= RMS_MAX, "smoothed level out of range")
	// The percent is clamped at one hundred.
	`SRLM_ASSERT_IMP(a_pct_range, out_ch.valid, out_ch.data.loudness_percent <= PCT_FULL, "percent above 100")
	// Once a block mean is handed over, the front end takes frames again.
	`SRLM_ASSERT_NXT(a_handoff_frees, mean_beat.valid && mean_ready, in_ch.ready, "front end stuck after block handoff")

endmodule

`default_nettype wire

// ===== rtl/srlm_square_acc.sv =====
`default_nettype none

module srlm_square_acc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	input  srlm_pkg::frame_t    frame,
	output logic                frame_ready,
	output srlm_pkg::mean_beat_t mean_beat,
	input  logic                mean_ready
);
	import srlm_pkg::*;

	localparam int MCAND_W = MAG_W + (MAG_DIGITS - 1) * DIGIT_W;
	localparam int SHIFT_W = MAG_DIGITS * DIGIT_W;
	localparam int PP_W = MCAND_W + DIGIT_W;

	typedef enum logic [2:0] {
		ACC_IDLE = 3'b001,
		ACC_MUL  = 3'b010,
		ACC_HOLD = 3'b100
	} acc_state_t;

	acc_state_t state_q;
	logic [DIG_CNT_W-1:0] dig_q;
	logic [SUM_W-1:0] sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [MCAND_W-1:0] mcand_l_q, mcand_r_q;
	logic [SHIFT_W-1:0] sh_l_q, sh_r_q;

	logic [MAG_W-1:0] mag_l, mag_r;
	logic [PP_W-1:0] pp_l, pp_r;
	logic [COUNT_W-1:0] count_next;
	logic last_digit;

	// Magnitude of floor(s / 2); the most negative sample gives 2^14.
	function automatic logic [MAG_W-1:0] half_mag(input logic [SAMPLE_W-1:0] s);
		logic [MAG_W-1:0] h;
		h = s[SAMPLE_W-1:1];
		return h[MAG_W-1] ? MAG_W'(~h + MAG_W'(1)) : h;
	endfunction

	assign mag_l = half_mag(frame.left_sample);
	assign mag_r = half_mag(frame.right_sample);

	// One multiplier digit per cycle; the multiplicand moves up one digit each step.
	assign pp_l = PP_W'(mcand_l_q) * PP_W'(sh_l_q[DIGIT_W-1:0]);
	assign pp_r = PP_W'(mcand_r_q) * PP_W'(sh_r_q[DIGIT_W-1:0]);

	assign count_next = count_q + COUNT_W'(1);
	assign last_digit = (dig_q == DIG_CNT_W'(MAG_DIGITS - 1));

	assign frame_ready = (state_q == ACC_IDLE);
	assign mean_beat.valid = (state_q == ACC_HOLD);
	assign mean_beat.mean = MEAN_W'({sum_q, 1'b0} >> BLOCK_LOG2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ACC_IDLE;
			dig_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ACC_IDLE: begin
					if (frame_valid) begin
						dig_q <= '0;
						state_q <= ACC_MUL;
					end
				end
				ACC_MUL: begin
					sum_q <= sum_q + SUM_W'(pp_l) + SUM_W'(pp_r);
					dig_q <= dig_q + DIG_CNT_W'(1);
					if (last_digit) begin
						count_q <= count_next;
						if (count_next == COUNT_W'(FRAMES_PER_BLOCK)) begin
							state_q <= ACC_HOLD;
						end else begin
							state_q <= ACC_IDLE;
						end
					end
				end
				ACC_HOLD: begin
					if (mean_ready) begin
						sum_q <= '0;
						count_q <= '0;
						state_q <= ACC_IDLE;
					end
				end
				default: begin
					state_q <= ACC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ACC_IDLE && frame_valid) begin
			mcand_l_q <= MCAND_W'(mag_l);
			mcand_r_q <= MCAND_W'(mag_r);
			sh_l_q <= SHIFT_W'(mag_l);
			sh_r_q <= SHIFT_W'(mag_r);
		end else if (state_q == ACC_MUL) begin
			mcand_l_q <= mcand_l_q << DIGIT_W;
			mcand_r_q <= mcand_r_q << DIGIT_W;
			sh_l_q <= sh_l_q >> DIGIT_W;
			sh_r_q <= sh_r_q >> DIGIT_W;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srlm_sqrt.sv =====
`default_nettype none

module srlm_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srlm_pkg::mean_beat_t mean_beat,
	output logic                 mean_ready,
	output srlm_pkg::rms_beat_t  rms_beat,
	input  logic                 rms_ready
);
	import srlm_pkg::*;

	localparam logic [ROOT_W-1:0] BIT_INIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_RUN  = 3'b010,
		SQ_DONE = 3'b100
	} sq_state_t;

	sq_state_t state_q;
	logic [ROOT_CNT_W-1:0] step_q;
	logic [ROOT_W-1:0] rem_q, root_q, bit_q;

	logic [ROOT_W-1:0] trial;
	logic fits;

	// Restoring root, one result bit per cycle.
	assign trial = root_q + bit_q;
	assign fits = (rem_q >= trial);

	assign mean_ready = (state_q == SQ_IDLE);
	assign rms_beat.valid = (state_q == SQ_DONE);
	assign rms_beat.rms = (root_q > ROOT_W'(RMS_MAX)) ? RMS_MAX : root_q[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (mean_beat.valid) begin
						step_q <= '0;
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					step_q <= step_q + ROOT_CNT_W'(1);
					if (step_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
						state_q <= SQ_DONE;
					end
				end
				SQ_DONE: begin
					if (rms_ready) begin
						state_q <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE && mean_beat.valid) begin
			rem_q <= ROOT_W'(mean_beat.mean);
			root_q <= '0;
			bit_q <= BIT_INIT;
		end else if (state_q == SQ_RUN) begin
			if (fits) begin
				rem_q <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srlm_smoother.sv =====
`default_nettype none

module srlm_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srlm_pkg::rms_beat_t           rms_beat,
	output logic                          rms_ready,
	input  logic [srlm_pkg::WEIGHT_W-1:0] weight,
	input  logic [srlm_pkg::LEVEL_W-1:0]  full_scale,
	output logic                          result_valid,
	output srlm_pkg::result_t             result,
	input  logic                          result_ready
);
	import srlm_pkg::*;

	localparam int MCAND_W = ACC_W + (W_DIGITS - 1) * DIGIT_W;
	localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'((64'd1 << WEIGHT_W) - 64'd1);

	typedef enum logic [5:0] {
		SM_IDLE = 6'b000001,
		SM_MUL  = 6'b000010,
		SM_UPD  = 6'b000100,
		SM_LVL  = 6'b001000,
		SM_DIV  = 6'b010000,
		SM_OUT  = 6'b100000
	} sm_state_t;

	sm_state_t state_q;
	logic [WDIG_CNT_W-1:0] dig_q;
	logic [PCT_CNT_W-1:0] step_q;
	logic [ACC_W-1:0] acc_q;
	logic res_valid_q;
	result_t res_q;

	logic [LEVEL_W-1:0] rms_q;
	logic up_q;
	logic [MCAND_W-1:0] mcand_q;
	logic [WEIGHT_W-1:0] wsh_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIVD_W-1:0] rem_q, dsr_q;
	logic [PCT_W-1:0] quo_q;

	logic [ACC_W-1:0] target, diff;
	logic up;
	logic [PROD_W-1:0] pp, prod_rnd;
	logic [LEVEL_W-1:0] level;
	logic [DIVD_W-1:0] lvl_x100;
	logic div_ge, out_free;

	assign target = {rms_beat.rms, {LVL_SHIFT{1'b0}}};
	assign up = (target >= acc_q);
	assign diff = up ? (target - acc_q) : (acc_q - target);

	assign pp = PROD_W'(mcand_q) * PROD_W'(wsh_q[DIGIT_W-1:0]);
	// A falling level rounds its step away from zero, matching a floor of a negative step.
	assign prod_rnd = prod_q + ROUND_ADD;

	assign level = acc_q[ACC_W-1 -: LEVEL_W];
	assign lvl_x100 = DIVD_W'(level) * DIVD_W'(PCT_FULL);
	assign div_ge = (rem_q >= dsr_q);
	assign out_free = !res_valid_q || result_ready;

	assign rms_ready = (state_q == SM_IDLE);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SM_IDLE;
			dig_q <= '0;
			step_q <= '0;
			acc_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == SM_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				SM_IDLE: begin
					if (rms_beat.valid) begin
						dig_q <= '0;
						state_q <= SM_MUL;
					end
				end
				SM_MUL: begin
					dig_q <= dig_q + WDIG_CNT_W'(1);
					if (dig_q == WDIG_CNT_W'(W_DIGITS - 1)) begin
						state_q <= SM_UPD;
					end
				end
				SM_UPD: begin
					if (up_q) begin
						acc_q <= acc_q + prod_q[PROD_W-1 -: ACC_W];
					end else begin
						acc_q <= acc_q - prod_rnd[PROD_W-1 -: ACC_W];
					end
					state_q <= SM_LVL;
				end
				SM_LVL: begin
					step_q <= '0;
					if (level >= full_scale) begin
						state_q <= SM_OUT;
					end else begin
						state_q <= SM_DIV;
					end
				end
				SM_DIV: begin
					step_q <= step_q + PCT_CNT_W'(1);
					if (step_q == PCT_CNT_W'(PCT_STEPS - 1)) begin
						state_q <= SM_OUT;
					end
				end
				SM_OUT: begin
					if (out_free) begin
						state_q <= SM_IDLE;
					end
				end
				default: begin
					state_q <= SM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SM_IDLE: begin
				if (rms_beat.valid) begin
					rms_q <= rms_beat.rms;
					up_q <= up;
					mcand_q <= MCAND_W'(diff);
					wsh_q <= weight;
					prod_q <= '0;
				end
			end
			SM_MUL: begin
				prod_q <= prod_q + pp;
				mcand_q <= mcand_q << DIGIT_W;
				wsh_q <= wsh_q >> DIGIT_W;
			end
			SM_LVL: begin
				rem_q <= lvl_x100;
				dsr_q <= DIVD_W'(full_scale) << (PCT_STEPS - 1);
				quo_q <= (level >= full_scale) ? PCT_FULL : '0;
			end
			SM_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsr_q;
				end
				quo_q <= {quo_q[PCT_W-2:0], div_ge};
				dsr_q <= dsr_q >> 1;
			end
			SM_OUT: begin
				if (out_free) begin
					res_q.block_rms <= rms_q;
					res_q.smoothed_level <= level;
					res_q.loudness_percent <= quo_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
